FILE: hw/rtl/dmq_pkg.sv
// ----------------------------------------------------------------------------
// dmq_pkg: shared types and constants of the double-ended mailbox queue
// Sizes of the slot ring, field widths, command codes and the structs passed
// between the top level and the queue core.
// ----------------------------------------------------------------------------
package dmq_pkg;

  // Ring size and element width
  localparam int DEPTH     = 16;
  localparam int ELEM_W    = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Port field widths
  localparam int COMMAND_W = 2;
  localparam int VALUE_W   = 32;
  localparam int CAP_W     = 5;
  localparam int COUNT_W   = 5;

  // Capacity after reset, saturated to the ring size
  localparam int CAP_RESET = (16 > DEPTH) ? DEPTH : 16;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_PUSH_HEAD = 2'd0,
    CMD_PUSH_TAIL = 2'd1,
    CMD_POP_HEAD  = 2'd2,
    CMD_POP_TAIL  = 2'd3
  } dmq_cmd_e;

  typedef struct packed {
    dmq_cmd_e           cmd;
    logic [VALUE_W-1:0] value;
  } dmq_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] pop_value;
    logic               accepted;
    logic [COUNT_W-1:0] stored_count;
  } dmq_res_t;

endpackage

FILE: hw/rtl/dmq_if.sv
// ----------------------------------------------------------------------------
// dmq_if: channel interfaces of the double-ended mailbox queue
// Command, response and capacity-write channels, each a valid/ready transfer.
// ----------------------------------------------------------------------------
interface dmq_cmd_if;
  import dmq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [COMMAND_W-1:0] command;
  logic [VALUE_W-1:0]   push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface dmq_rsp_if;
  import dmq_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] pop_value;
  logic               accepted;
  logic [COUNT_W-1:0] stored_count;

  modport source (output valid, output pop_value, output accepted, output stored_count,
                  input ready);
  modport sink   (input valid, input pop_value, input accepted, input stored_count,
                  output ready);
endinterface

interface dmq_cfg_if;
  import dmq_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

FILE: hw/rtl/dmq_core.sv
// ----------------------------------------------------------------------------
// dmq_core: slot ring, end indices and fill state of the queue
// Executes one command per enabled cycle and registers its result.
// ----------------------------------------------------------------------------
module dmq_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 exec_i,
  input  dmq_pkg::dmq_op_t     op_i,
  input  logic                 cfg_we_i,
  input  logic [dmq_pkg::CAP_W-1:0] cfg_cap_i,
  output dmq_pkg::dmq_res_t    res_o
);
  import dmq_pkg::*;

  logic [ELEM_W-1:0]  mem [DEPTH];

  logic [CNT_W-1:0]   cap_q, free_q, free_d;
  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [IDX_W-1:0]   head_nxt, tail_nxt, head_prv, tail_prv;
  logic [IDX_W-1:0]   wr_idx, rd_idx;
  logic [CNT_W-1:0]   cap_new;
  logic               is_push, ok, do_wr, do_rd;

  logic [VALUE_W-1:0] pop_value_q;
  logic               accepted_q;
  logic [COUNT_W-1:0] count_q;

  function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] idx,
                                                  logic [CNT_W-1:0] cap);
    logic [CNT_W:0] nxt;
    nxt = (CNT_W+1)'(idx) + 1'b1;
    ring_next = (nxt >= (CNT_W+1)'(cap)) ? '0 : nxt[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(logic [IDX_W-1:0] idx,
                                                  logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] last;
    last = cap - 1'b1;
    if (idx == '0 || (CNT_W+1)'(idx) >= (CNT_W+1)'(cap)) begin
      ring_prev = last[IDX_W-1:0];
    end else begin
      ring_prev = idx - 1'b1;
    end
  endfunction

  // Saturate the written capacity into 1..DEPTH
  always_comb begin
    if (cfg_cap_i == '0) begin
      cap_new = CNT_W'(1);
    end else if (32'(cfg_cap_i) > DEPTH) begin
      cap_new = CNT_W'(DEPTH);
    end else begin
      cap_new = CNT_W'(cfg_cap_i);
    end
  end

  always_comb begin
    head_nxt = ring_next(head_q, cap_q);
    tail_nxt = ring_next(tail_q, cap_q);
    head_prv = ring_prev(head_q, cap_q);
    tail_prv = ring_prev(tail_q, cap_q);

    is_push = (op_i.cmd == CMD_PUSH_HEAD) || (op_i.cmd == CMD_PUSH_TAIL);
    ok      = is_push ? (free_q != '0) : (free_q != cap_q);
    do_wr   = exec_i && ok && is_push;
    do_rd   = exec_i && ok && !is_push;

    head_d = head_q;
    tail_d = tail_q;
    free_d = free_q;
    wr_idx = tail_q;
    rd_idx = head_q;

    case (op_i.cmd)
      CMD_PUSH_HEAD: begin
        wr_idx = head_nxt;
        if (ok) begin
          head_d = head_nxt;
          free_d = free_q - 1'b1;
        end
      end
      CMD_PUSH_TAIL: begin
        wr_idx = tail_q;
        if (ok) begin
          tail_d = tail_prv;
          free_d = free_q - 1'b1;
        end
      end
      CMD_POP_HEAD: begin
        rd_idx = head_q;
        if (ok) begin
          head_d = head_prv;
          free_d = free_q + 1'b1;
        end
      end
      CMD_POP_TAIL: begin
        rd_idx = tail_nxt;
        if (ok) begin
          tail_d = tail_nxt;
          free_d = free_q + 1'b1;
        end
      end
      default: begin
        rd_idx = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CNT_W'(CAP_RESET);
      free_q <= CNT_W'(CAP_RESET);
      head_q <= '0;
      tail_q <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cap_new;
      free_q <= cap_new;
      head_q <= '0;
      tail_q <= '0;
    end else if (exec_i) begin
      free_q <= free_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Slot ring and result register; hold the result while no command runs
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_idx] <= ELEM_W'(op_i.value);
    end
    if (exec_i) begin
      pop_value_q <= do_rd ? VALUE_W'(mem[rd_idx]) : '0;
      accepted_q  <= ok;
      count_q     <= COUNT_W'(cap_q - free_d);
    end
  end

  assign res_o.pop_value    = pop_value_q;
  assign res_o.accepted     = accepted_q;
  assign res_o.stored_count = count_q;

endmodule

FILE: hw/rtl/double_ended_mailbox_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_mailbox_queue_top: double-ended queue on a ring of slots
// Each command pushes or pops one element at the head or the tail end; a push
// into a full queue or a pop from an empty one is refused and flagged.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i  carries one command per transfer: push head, push tail, pop head or
//          pop tail, with the element to store on a push.
//   rsp_o  returns one response per command: the popped element (zero on a
//          push or a refused pop), the accepted flag and the fill count after
//          the command.
//   cfg_i  writes the capacity (1..16 slots; 0 acts as 1, larger values act
//          as 16). A write empties the queue. Write only while idle: no
//          command taken whose response is still outstanding.
// Timing: a command passes from its transfer on cmd_i to its response on rsp_o
//   through the input register, then the result register in the core.
//   One command per cycle is sustained while rsp_o is ready; the limit is the single
//   write/read port of the slot ring, used once per command.
// Reset: the queue is empty, the capacity is 16, no response is pending.
// Stall: while rsp_o is held off the response stays registered and the input
//   register may still take one more command; then cmd_i.ready drops.
// ----------------------------------------------------------------------------
module double_ended_mailbox_queue_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  dmq_cmd_if.sink   cmd_i,
  dmq_rsp_if.source rsp_o,
  dmq_cfg_if.sink   cfg_i
);
  import dmq_pkg::*;

  logic     in_valid_q;
  dmq_op_t  op_q;
  logic     out_valid_q;
  logic     exec;
  dmq_res_t res;

  // Advance the held command when the result register is free or draining
  assign exec        = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign cmd_i.ready = !in_valid_q || exec;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ready) begin
        in_valid_q <= cmd_i.valid;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the command payload on each transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      op_q.cmd   <= dmq_cmd_e'(cmd_i.command);
      op_q.value <= cmd_i.push_value;
    end
  end

  dmq_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exec_i    (exec),
    .op_i      (op_q),
    .cfg_we_i  (cfg_i.valid),
    .cfg_cap_i (cfg_i.capacity),
    .res_o     (res)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.pop_value    = res.pop_value;
  assign rsp_o.accepted     = res.accepted;
  assign rsp_o.stored_count = res.stored_count;

endmodule

FILE: test/double_ended_mailbox_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_mailbox_queue_top_tb: self-checking bench for the mailbox deque
// Pushes and pops at both ends under several capacities and random back
// pressure. A mirror of the ring predicts every response, and each response
// is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_mailbox_queue_top_tb;
  import dmq_pkg::*;

  // Mirror of the slot ring: tracks the indexes, the fill level and the
  // elements, and keeps the responses that the block still owes.
  class deque_mirror;
    int unsigned        cap;
    int unsigned        head_pos;
    int unsigned        tail_pos;
    int unsigned        free_n;
    logic [VALUE_W-1:0] ring [DEPTH];
    dmq_res_t           owed[$];
    int unsigned        mismatches;
    int unsigned        n_commands;
    int unsigned        n_pushes_ok;
    int unsigned        n_pops_ok;
    int unsigned        n_refused;
    int unsigned        n_cap_writes;

    function new();
      foreach (ring[i]) ring[i] = '0;
      cap = CAP_RESET;
      head_pos = 0;
      tail_pos = 0;
      free_n = cap;
    endfunction

    // A write saturates into 1..DEPTH and empties the queue.
    function void set_capacity(logic [CAP_W-1:0] v);
      if (v == 0) cap = 1;
      else if (v > DEPTH) cap = DEPTH;
      else cap = v;
      head_pos = 0;
      tail_pos = 0;
      free_n = cap;
      n_cap_writes++;
    endfunction

    function int unsigned ring_fwd(int unsigned i);
      return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function int unsigned ring_back(int unsigned i);
      return (i == 0 || i >= cap) ? cap - 1 : i - 1;
    endfunction

    function void apply_command(dmq_cmd_e c, logic [VALUE_W-1:0] v);
      dmq_res_t r;
      r = '0;
      n_commands++;
      if (c == CMD_PUSH_HEAD || c == CMD_PUSH_TAIL) begin
        if (free_n > 0) begin
          free_n--;
          if (c == CMD_PUSH_TAIL) begin
            ring[tail_pos] = v;
            tail_pos = ring_back(tail_pos);
          end else begin
            head_pos = ring_fwd(head_pos);
            ring[head_pos] = v;
          end
          r.accepted = 1'b1;
          n_pushes_ok++;
        end
      end else if (free_n < cap) begin
        free_n++;
        if (c == CMD_POP_TAIL) begin
          tail_pos = ring_fwd(tail_pos);
          r.pop_value = ring[tail_pos];
        end else begin
          r.pop_value = ring[head_pos];
          head_pos = ring_back(head_pos);
        end
        r.accepted = 1'b1;
        n_pops_ok++;
      end
      if (!r.accepted) n_refused++;
      r.stored_count = COUNT_W'(cap - free_n);
      owed.push_back(r);
    endfunction

    function void report(string what, dmq_res_t want, dmq_res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected pop_value=%h accepted=%b count=%0d,",
                 $time, what, want.pop_value, want.accepted, want.stored_count,
                 " got pop_value=%h accepted=%b count=%0d",
                 got.pop_value, got.accepted, got.stored_count);
    endfunction

    function void compare_response(dmq_res_t got);
      dmq_res_t want;
      if (owed.size() == 0) begin
        report("response with nothing outstanding", '0, got);
        return;
      end
      want = owed.pop_front();
      if (got.pop_value !== want.pop_value || got.accepted !== want.accepted ||
          got.stored_count !== want.stored_count)
        report("response mismatch", want, got);
    endfunction

    // Count every response that never arrived.
    function void close_out();
      if (owed.size() != 0)
        $display("%0d responses never arrived", owed.size());
      mismatches += owed.size();
      owed.delete();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  dmq_cmd_if cmd_if ();
  dmq_rsp_if rsp_if ();
  dmq_cfg_if cfg_if ();

  double_ended_mailbox_queue_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  deque_mirror queue_model;
  int          tx_idle_pct;  // chance per cycle that the command side idles
  int          rx_idle_pct;  // chance per cycle that the response side stalls
  logic        rx_hold;      // long response stall, set by hold_responses

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Response side: check each transfer, then pick ready for the next edge.
  initial begin
    dmq_res_t got;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.pop_value    = rsp_if.pop_value;
        got.accepted     = rsp_if.accepted;
        got.stored_count = rsp_if.stored_count;
        queue_model.compare_response(got);
      end
      rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Hold off the response side for a fixed number of cycles so that the
  // block backs up and drops cmd_i.ready while commands keep coming.
  task automatic hold_responses(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  // Idle a random number of cycles, then offer one command, wait for its
  // transfer and predict its response.
  task automatic send_command(dmq_cmd_e c, logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= c;
    cmd_if.push_value <= v;
    do @(posedge clk_i); while (!cmd_if.ready);
    queue_model.apply_command(c, v);
  endtask

  // Wait until every owed response is in, then let the pipeline settle.
  task automatic drain_responses();
    int guard;
    guard = 0;
    while (queue_model.owed.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(logic [CAP_W-1:0] v);
    cmd_if.valid <= 1'b0;
    drain_responses();
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    queue_model.set_capacity(v);
  endtask

  // Edge values show up often; the rest is uniform.
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Bursts lean toward filling, draining or staying level, so both the full
  // and the empty queue come up again and again, with random ends mixed in.
  task automatic run_random_phase(int n_items);
    int       done;
    int       burst;
    int       lean;
    int       push_pct;
    logic     pop_bit;
    logic     tail_bit;
    dmq_cmd_e c;
    done = 0;
    while (done < n_items) begin
      burst = $urandom_range(40, 4);
      if (burst > n_items - done) burst = n_items - done;
      lean = $urandom_range(2);
      push_pct = (lean == 0) ? 80 : (lean == 1) ? 20 : 50;
      repeat (burst) begin
        pop_bit  = ($urandom_range(99) >= push_pct);
        tail_bit = 1'($urandom_range(1));
        c = dmq_cmd_e'({pop_bit, tail_bit});
        send_command(c, pick_value());
        done++;
      end
    end
  endtask

  initial begin
    queue_model = new();
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_PUSH_HEAD;
    cmd_if.push_value = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.capacity   = '0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    rx_hold           = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: pops on the empty queue, one element from each end,
    // both taken back at the head so the head pointer wraps below zero.
    send_command(CMD_POP_HEAD, 32'h0);
    send_command(CMD_POP_TAIL, 32'hFFFF_FFFF);
    send_command(CMD_PUSH_HEAD, 32'h0000_0000);
    send_command(CMD_PUSH_TAIL, 32'hFFFF_FFFF);
    send_command(CMD_POP_HEAD, 32'h0);
    send_command(CMD_POP_HEAD, 32'h0);
    send_command(CMD_POP_TAIL, 32'h0);

    // Zero saturates to one slot: fill it, refuse pushes at both ends,
    // empty it, refuse the pop, then cross from head push to tail pop.
    write_capacity(5'd0);
    send_command(CMD_PUSH_TAIL, 32'hA5A5_A5A5);
    send_command(CMD_PUSH_HEAD, 32'h5A5A_5A5A);
    send_command(CMD_PUSH_TAIL, 32'h5A5A_5A5A);
    send_command(CMD_POP_TAIL, 32'h0);
    send_command(CMD_POP_HEAD, 32'h0);
    send_command(CMD_PUSH_HEAD, 32'h1234_5678);
    send_command(CMD_POP_TAIL, 32'h0);

    // Two slots: full from both ends, then drain from the tail.
    write_capacity(5'd2);
    send_command(CMD_PUSH_HEAD, 32'h8000_0000);
    send_command(CMD_PUSH_TAIL, 32'h0000_0001);
    send_command(CMD_PUSH_HEAD, 32'hFFFF_FFFF);
    send_command(CMD_POP_TAIL, 32'h0);
    send_command(CMD_POP_TAIL, 32'h0);
    send_command(CMD_POP_HEAD, 32'h0);

    // Random phases: each writes a new capacity and sets its idle pattern.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_capacity(5'd31);
        1: write_capacity(5'd3);
        2: write_capacity(5'd1);
        3: write_capacity(CAP_W'($urandom_range(16, 1)));
        4: write_capacity(5'd16);
        default: write_capacity(CAP_W'($urandom_range(31)));
      endcase
      if (ph < 2) begin
        tx_idle_pct = 28;
        rx_idle_pct <= 53;
      end else if (ph < 4) begin
        tx_idle_pct = 53;
        rx_idle_pct <= 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      // Stall responses for a long stretch while commands keep streaming.
      if (ph == 4)
        fork
          hold_responses(80);
        join_none
      run_random_phase(190);
    end

    cmd_if.valid <= 1'b0;
    drain_responses();
    queue_model.close_out();

    $display("Ran %0d commands over %0d capacity writes:",
             queue_model.n_commands, queue_model.n_cap_writes);
    $display("%0d pushes and %0d pops taken, %0d refused",
             queue_model.n_pushes_ok, queue_model.n_pops_ok, queue_model.n_refused);
    if (queue_model.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures in total", queue_model.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
